@@ hw/rtl/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Shared constants, status and action codes, and the result word type.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int MAX_ORDER_DEF = 10;
    localparam int PAGE_W        = 11;
    localparam int OFF_W         = 10;
    localparam int STATUS_W      = 2;
    localparam int ORD_W         = $clog2(PAGE_W + 1);

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_BLOCK = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_REQ  = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFF_W-1:0]    granted_offset;
        logic [PAGE_W-1:0]   granted_pages;
        logic [PAGE_W-1:0]   free_total;
    } result_t;

endpackage

@@ hw/rtl/buddy_page_allocator.sv @@
// ----------------------------------------------------------------------------
// Buddy page allocator
// Allocates and frees power-of-two page blocks over a configurable region.
// ----------------------------------------------------------------------------
// One request is handled at a time. The free marks sit in one memory row per
// block order; each step reads a row through the registered read port, and the
// steps that change a row write it back once that read has returned it. An
// allocate searches the orders upward from the requested one and then splits
// down level by level; a free checks every row for overlap and then merges
// upward level by level; rejected words go from decode straight to the result.
// After reset and after every write of the region size through cfg_data a
// clearing pass rebuilds the marks, during which no word is accepted.
// A finished result waits in an output register while the next word is taken.
module buddy_page_allocator #(
    parameter int MAX_ORDER = bpa_pkg::MAX_ORDER_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // page_count, block_offset, zero pad
    input  logic [0:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // granted_offset, granted_pages, free_total
    output logic [1:0]  m_axis_tuser    // status
);

    localparam int NP = 1 << MAX_ORDER;
    localparam int AW = (MAX_ORDER + 1 > 1) ? $clog2(MAX_ORDER + 1) : 1;

    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [NP-1:0]          rd_data;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [NP-1:0]          wr_data;
    logic                   res_valid;
    logic                   res_ready;
    bpa_pkg::result_t       res;
    bpa_pkg::result_t       out_reg;
    logic                   out_valid_reg;

    bpa_mark_mem #(
        .ROWS   (MAX_ORDER + 1),
        .WIDTH  (NP),
        .ADDR_W (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    bpa_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser[0]),
        .in_count  (s_axis_tdata[10:0]),
        .in_offset (s_axis_tdata[20:11]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.free_total, out_reg.granted_pages, out_reg.granted_offset};
    assign m_axis_tuser  = out_reg.status;

endmodule

@@ hw/rtl/bpa_mark_mem.sv @@
// ----------------------------------------------------------------------------
// Buddy page allocator free-mark memory
// One row of free marks per block order, registered read, single write port.
// ----------------------------------------------------------------------------
module bpa_mark_mem #(
    parameter int ROWS   = 11,
    parameter int WIDTH  = 1024,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [ROWS];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/bpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Buddy page allocator sequencer
// Clearing pass, request decode, order search, split, overlap check and merge
// over the free-mark memory, one row read per step and written back where it changes.
// ----------------------------------------------------------------------------
module bpa_ctrl #(
    parameter int MAX_ORDER = bpa_pkg::MAX_ORDER_DEF,
    localparam int NP       = 1 << MAX_ORDER,
    localparam int AW       = (MAX_ORDER + 1 > 1) ? $clog2(MAX_ORDER + 1) : 1,
    localparam int IW       = MAX_ORDER
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bpa_pkg::PAGE_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_action,
    input  logic [bpa_pkg::PAGE_W-1:0]    in_count,
    input  logic [bpa_pkg::OFF_W-1:0]     in_offset,
    output logic                          res_valid,
    input  logic                          res_ready,
    output bpa_pkg::result_t              res,
    output logic                          rd_en,
    output logic [AW-1:0]                 rd_addr,
    input  logic [NP-1:0]                 rd_data,
    output logic                          wr_en,
    output logic [AW-1:0]                 wr_addr,
    output logic [NP-1:0]                 wr_data
);

    localparam int WW = (MAX_ORDER + 2 > bpa_pkg::PAGE_W + 1) ?
                        MAX_ORDER + 2 : bpa_pkg::PAGE_W + 1;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_A_RD  = 4'd3;
    localparam logic [3:0] S_A_CHK = 4'd4;
    localparam logic [3:0] S_S_RD  = 4'd5;
    localparam logic [3:0] S_S_WR  = 4'd6;
    localparam logic [3:0] S_F_RD  = 4'd7;
    localparam logic [3:0] S_F_CHK = 4'd8;
    localparam logic [3:0] S_M_RD  = 4'd9;
    localparam logic [3:0] S_M_CHK = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    localparam logic [AW-1:0] TOP_ROW = AW'(MAX_ORDER);

    logic [3:0]                     state_reg, state_next;
    logic [AW-1:0]                  k_reg, k_next;
    logic [AW-1:0]                  ord_reg, ord_next;
    logic [IW-1:0]                  i_reg, i_next;
    logic [bpa_pkg::PAGE_W-1:0]     region_reg, region_next;
    logic [bpa_pkg::PAGE_W-1:0]     ft_reg, ft_next;
    logic                           act_reg, act_next;
    logic [bpa_pkg::PAGE_W-1:0]     cnt_reg, cnt_next;
    logic [bpa_pkg::OFF_W-1:0]      off_reg, off_next;
    bpa_pkg::result_t               res_reg, res_next;

    logic [WW-1:0]                  r_eff;
    logic [WW-1:0]                  r_shift;
    logic [NP-1:0]                  init_row;
    logic [bpa_pkg::ORD_W-1:0]      ord_raw;
    logic [WW-1:0]                  size_raw;
    logic [WW-1:0]                  size_w;
    logic [bpa_pkg::PAGE_W-1:0]     size_p;
    logic [WW-1:0]                  off_w;
    logic [WW-1:0]                  lo_w;
    logic [WW-1:0]                  hi_w;
    logic [NP-1:0]                  ovl_mask;
    logic                           hit;
    logic [IW-1:0]                  hit_idx;
    logic [NP-1:0]                  one_i;
    logic [NP-1:0]                  one_hit;
    logic [NP-1:0]                  one_bud;
    logic [NP-1:0]                  one_odd;
    logic [IW-1:0]                  bud_idx;

    always_comb
    begin
        if (WW'(region_reg) > WW'(NP))
        begin
            r_eff = WW'(NP);
        end
        else
        begin
            r_eff = WW'(region_reg);
        end
        r_shift  = r_eff >> k_reg;
        init_row = '0;
        if (r_shift[0])
        begin
            init_row = NP'(1) << IW'(r_shift & ~WW'(1));
        end
    end

    always_comb
    begin
        ord_raw = '0;
        for (int j = bpa_pkg::PAGE_W; j >= 0; j--)
        begin
            if ((WW'(1) << j) >= WW'(cnt_reg))
            begin
                ord_raw = bpa_pkg::ORD_W'(j);
            end
        end
        size_raw = WW'(1) << ord_raw;
        size_w   = WW'(1) << ord_reg;
        size_p   = bpa_pkg::PAGE_W'(size_w);
        off_w    = WW'(off_reg);
        lo_w     = off_w >> k_reg;
        hi_w     = (off_w + size_w - WW'(1)) >> k_reg;
        for (int b = 0; b < NP; b++)
        begin
            ovl_mask[b] = (WW'(b) >= lo_w) && (WW'(b) <= hi_w);
        end
    end

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int b = NP - 1; b >= 0; b--)
        begin
            if (rd_data[b])
            begin
                hit     = 1'b1;
                hit_idx = IW'(b);
            end
        end
        bud_idx = i_reg ^ IW'(1);
        one_i   = NP'(1) << i_reg;
        one_hit = NP'(1) << hit_idx;
        one_bud = NP'(1) << bud_idx;
        one_odd = NP'(1) << (i_reg | IW'(1));
    end

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        ord_next    = ord_reg;
        i_next      = i_reg;
        region_next = region_reg;
        ft_next     = ft_reg;
        act_next    = act_reg;
        cnt_next    = cnt_reg;
        off_next    = off_reg;
        res_next    = res_reg;
        rd_en       = 1'b0;
        rd_addr     = k_reg;
        wr_en       = 1'b0;
        wr_addr     = k_reg;
        wr_data     = rd_data;

        case (state_reg)
            S_INIT:
            begin
                wr_en   = 1'b1;
                wr_data = init_row;
                if (k_reg == TOP_ROW)
                begin
                    ft_next    = bpa_pkg::PAGE_W'(r_eff);
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next = k_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = in_action;
                    cnt_next   = in_count;
                    off_next   = in_offset;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                ord_next = AW'(ord_raw);
                k_next   = AW'(ord_raw);
                res_next.granted_offset = '0;
                res_next.granted_pages  = '0;
                res_next.free_total     = ft_reg;
                if ((int'(ord_raw) > MAX_ORDER) || (size_raw > r_eff))
                begin
                    res_next.status = bpa_pkg::ST_BAD_REQ;
                    state_next      = S_DONE;
                end
                else if (act_reg == bpa_pkg::ACT_ALLOC)
                begin
                    if (size_raw > WW'(ft_reg))
                    begin
                        res_next.status = bpa_pkg::ST_NO_BLOCK;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_A_RD;
                    end
                end
                else
                begin
                    if (((off_w & (size_raw - WW'(1))) != '0) ||
                        ((off_w + size_raw) > r_eff))
                    begin
                        res_next.status = bpa_pkg::ST_BAD_REQ;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        k_next     = '0;
                        state_next = S_F_RD;
                    end
                end
            end
            S_A_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                if (hit)
                begin
                    wr_en      = 1'b1;
                    wr_data    = rd_data & ~one_hit;
                    i_next     = hit_idx;
                    state_next = S_S_RD;
                end
                else if (k_reg == TOP_ROW)
                begin
                    res_next.status = bpa_pkg::ST_NO_BLOCK;
                    state_next      = S_DONE;
                end
                else
                begin
                    k_next     = k_reg + AW'(1);
                    state_next = S_A_RD;
                end
            end
            S_S_RD:
            begin
                if (k_reg == ord_reg)
                begin
                    ft_next                 = ft_reg - size_p;
                    res_next.status         = bpa_pkg::ST_OK;
                    res_next.granted_offset = bpa_pkg::OFF_W'(WW'(i_reg) << ord_reg);
                    res_next.granted_pages  = size_p;
                    res_next.free_total     = ft_reg - size_p;
                    state_next              = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = k_reg - AW'(1);
                    k_next     = k_reg - AW'(1);
                    i_next     = i_reg << 1;
                    state_next = S_S_WR;
                end
            end
            S_S_WR:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data | one_odd;
                state_next = S_S_RD;
            end
            S_F_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                if ((rd_data & ovl_mask) != '0)
                begin
                    res_next.status = bpa_pkg::ST_NO_BLOCK;
                    state_next      = S_DONE;
                end
                else if (k_reg == TOP_ROW)
                begin
                    k_next     = ord_reg;
                    i_next     = IW'(off_w >> ord_reg);
                    state_next = S_M_RD;
                end
                else
                begin
                    k_next     = k_reg + AW'(1);
                    state_next = S_F_RD;
                end
            end
            S_M_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_M_CHK;
            end
            S_M_CHK:
            begin
                wr_en = 1'b1;
                if ((k_reg != TOP_ROW) && rd_data[bud_idx])
                begin
                    wr_data    = rd_data & ~one_bud;
                    i_next     = i_reg >> 1;
                    k_next     = k_reg + AW'(1);
                    state_next = S_M_RD;
                end
                else
                begin
                    wr_data                 = rd_data | one_i;
                    ft_next                 = ft_reg + size_p;
                    res_next.status         = bpa_pkg::ST_OK;
                    res_next.granted_offset = '0;
                    res_next.granted_pages  = size_p;
                    res_next.free_total     = ft_reg + size_p;
                    state_next              = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            region_next = cfg_data;
            k_next      = '0;
            state_next  = S_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            k_reg      <= '0;
            region_reg <= bpa_pkg::PAGE_W'(1024);
            ft_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            region_reg <= region_next;
            ft_reg     <= ft_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ord_reg <= ord_next;
        i_reg   <= i_next;
        act_reg <= act_next;
        cnt_reg <= cnt_next;
        off_reg <= off_next;
        res_reg <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

@@ tb/buddy_page_allocator_tb.sv @@
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Drives allocate and free words through the slave stream, predicts each
// result with a local buddy tree model and checks every field of the master
// stream. Runs a directed table, then random phases over several region sizes.
// ----------------------------------------------------------------------------
module buddy_page_allocator_tb;

    localparam int NPAGES = 1024;
    localparam int NORD   = 10;
    localparam int NNODES = 2 * NPAGES - 1;

    typedef struct packed {
        logic        act;
        logic [10:0] count;
        logic [9:0]  offset;
    } request_t;

    typedef struct {
        request_t         req;
        logic             known;
        bpa_pkg::result_t res;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [10:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    logic             marks[NNODES];
    int               region;
    int               pages_free;
    bpa_pkg::result_t pending_results[$];
    int               err_count;
    int               words_sent;
    int               results_seen;
    bit               quiet;
    int               held_offs[$];
    int               held_sizes[$];

    buddy_page_allocator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic bit mark_rd(int k, int i);
        if (k > NORD || i < 0 || i >= (NPAGES >> k))
            return 1'b0;
        return marks[(NPAGES >> k) - 1 + i];
    endfunction

    function automatic void mark_wr(int k, int i, bit v);
        if (k > NORD || i < 0 || i >= (NPAGES >> k))
            return;
        marks[(NPAGES >> k) - 1 + i] = v;
    endfunction

    function automatic void rebuild_tree(int value);
        int off;
        region = (value > NPAGES) ? NPAGES : value;
        off = 0;
        foreach (marks[n])
            marks[n] = 1'b0;
        for (int k = NORD; k >= 0; k--)
        begin
            if (region & (1 << k))
            begin
                mark_wr(k, off >> k, 1'b1);
                off += 1 << k;
            end
        end
        pages_free = region;
        held_offs.delete();
        held_sizes.delete();
    endfunction

    function automatic bit overlaps_free(int k, int i);
        int a;
        a = i;
        for (int j = k; j <= NORD; j++)
        begin
            if (mark_rd(j, a))
                return 1'b1;
            a = a >> 1;
        end
        for (int j = 0; j < k; j++)
            for (int t = 0; t < (1 << (k - j)); t++)
                if (mark_rd(j, (i << (k - j)) + t))
                    return 1'b1;
        return 1'b0;
    endfunction

    function automatic bpa_pkg::result_t allocate_or_free(request_t rq);
        bpa_pkg::result_t r;
        int size, ord, k, i;
        bit found;
        size = 1;
        ord = 0;
        r = '0;
        r.status = bpa_pkg::ST_OK;
        while (size < rq.count && ord <= NORD)
        begin
            size = size << 1;
            ord++;
        end
        if (ord > NORD || size > region)
            r.status = bpa_pkg::ST_BAD_REQ;
        else if (rq.act == bpa_pkg::ACT_ALLOC)
        begin
            found = 1'b0;
            if (size <= pages_free)
            begin
                for (k = ord; k <= NORD && !found; k++)
                    for (i = 0; i < (NPAGES >> k) && !found; i++)
                        if (mark_rd(k, i))
                            found = 1'b1;
                k--;
                i--;
            end
            if (!found)
                r.status = bpa_pkg::ST_NO_BLOCK;
            else
            begin
                mark_wr(k, i, 1'b0);
                for (int j = k; j > ord; j--)
                begin
                    i = i << 1;
                    mark_wr(j - 1, i + 1, 1'b1);
                end
                r.granted_offset = 10'(i << ord);
                r.granted_pages = 11'(size);
                pages_free -= size;
                held_offs.push_back(i << ord);
                held_sizes.push_back(size);
            end
        end
        else
        begin
            k = ord;
            i = rq.offset >> ord;
            if ((rq.offset & (size - 1)) != 0 || rq.offset + size > region)
                r.status = bpa_pkg::ST_BAD_REQ;
            else if (overlaps_free(k, i))
                r.status = bpa_pkg::ST_NO_BLOCK;
            else
            begin
                while (k < NORD && mark_rd(k, i ^ 1))
                begin
                    mark_wr(k, i ^ 1, 1'b0);
                    i = i >> 1;
                    k++;
                end
                mark_wr(k, i, 1'b1);
                pages_free += size;
                r.granted_pages = 11'(size);
            end
        end
        r.free_total = 11'(pages_free);
        return r;
    endfunction

    task automatic send_word(request_t rq);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, rq.offset, rq.count};
        s_axis_tuser  <= rq.act;
        do
            @(posedge clk);
        while (!s_axis_tready);
        words_sent++;
        @(negedge clk);
        if (!quiet && $urandom_range(99) < 8)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
    endtask

    task automatic issue(request_t rq, bit known, bpa_pkg::result_t want);
        bpa_pkg::result_t r;
        r = allocate_or_free(rq);
        if (known && r != want)
        begin
            $error("directed row disagrees with predictor: %h vs %h", want, r);
            err_count++;
        end
        pending_results.push_back(r);
        send_word(rq);
    endtask

    task automatic drain_and_configure(int value);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value[10:0];
        @(negedge clk);
        cfg_we   <= 1'b0;
        rebuild_tree(value);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            bpa_pkg::result_t got, want;
            got = {m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[20:10], m_axis_tdata[31:21]};
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word %h", got);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    err_count++;
                end
                if (got.granted_offset !== want.granted_offset)
                begin
                    $error("granted_offset: expected %0d, actual %0d",
                           want.granted_offset, got.granted_offset);
                    err_count++;
                end
                if (got.granted_pages !== want.granted_pages)
                begin
                    $error("granted_pages: expected %0d, actual %0d",
                           want.granted_pages, got.granted_pages);
                    err_count++;
                end
                if (got.free_total !== want.free_total)
                begin
                    $error("free_total: expected %0d, actual %0d",
                           want.free_total, got.free_total);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 8);
        end
    end

    function automatic request_t rand_request();
        request_t rq;
        int pick, idx, sz;
        pick = $urandom_range(99);
        rq.offset = 10'($urandom);
        if (pick < 45)
        begin
            rq.act = bpa_pkg::ACT_ALLOC;
            sz = 1 << $urandom_range(($urandom_range(9) == 0) ? 10 : 5);
            rq.count = 11'(($urandom_range(3) == 0) ? sz : $urandom_range(sz, sz / 2 + 1));
        end
        else if (pick < 85 && held_offs.size() != 0)
        begin
            idx = $urandom_range(held_offs.size() - 1);
            rq.act = bpa_pkg::ACT_FREE;
            rq.count = 11'(held_sizes[idx]);
            rq.offset = 10'(held_offs[idx]);
            held_offs.delete(idx);
            held_sizes.delete(idx);
        end
        else
        begin
            rq.act = 1'($urandom);
            rq.count = 11'($urandom);
        end
        return rq;
    endfunction

    table_row_t directed[$];
    int         settings[6] = '{1024, 1, 0, 2047, 700, 37};

    function automatic table_row_t row(logic a, int c, int o, logic kn,
                                       logic [1:0] st, int go, int gp, int ft);
        table_row_t t;
        t.req = '{a, c[10:0], o[9:0]};
        t.known = kn;
        t.res = '{st, go[9:0], gp[10:0], ft[10:0]};
        return t;
    endfunction

    initial
    begin
        cfg_we = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        rst_n = 1'b0;
        err_count = 0;
        words_sent = 0;
        results_seen = 0;
        quiet = 1'b0;
        rebuild_tree(1024);
        directed = '{
            row(bpa_pkg::ACT_ALLOC, 2047, 0,    1, bpa_pkg::ST_BAD_REQ,  0, 0,    1024),
            row(bpa_pkg::ACT_ALLOC, 1025, 0,    1, bpa_pkg::ST_BAD_REQ,  0, 0,    1024),
            row(bpa_pkg::ACT_FREE,  1,    0,    1, bpa_pkg::ST_NO_BLOCK, 0, 0,    1024),
            row(bpa_pkg::ACT_ALLOC, 0,    1023, 1, bpa_pkg::ST_OK,       0, 1,    1023),
            row(bpa_pkg::ACT_FREE,  2,    1,    1, bpa_pkg::ST_BAD_REQ,  0, 0,    1023),
            row(bpa_pkg::ACT_ALLOC, 3,    0,    1, bpa_pkg::ST_OK,       4, 4,    1019),
            row(bpa_pkg::ACT_ALLOC, 1024, 0,    1, bpa_pkg::ST_NO_BLOCK, 0, 0,    1019),
            row(bpa_pkg::ACT_FREE,  1,    1,    0, bpa_pkg::ST_OK,       0, 0,    0),
            row(bpa_pkg::ACT_FREE,  1,    0,    0, bpa_pkg::ST_OK,       0, 0,    0),
            row(bpa_pkg::ACT_FREE,  4,    4,    0, bpa_pkg::ST_OK,       0, 0,    0),
            row(bpa_pkg::ACT_ALLOC, 1024, 0,    1, bpa_pkg::ST_OK,       0, 1024, 0),
            row(bpa_pkg::ACT_ALLOC, 1,    0,    1, bpa_pkg::ST_NO_BLOCK, 0, 0,    0),
            row(bpa_pkg::ACT_FREE,  512,  512,  0, bpa_pkg::ST_OK,       0, 0,    0),
            row(bpa_pkg::ACT_FREE,  1024, 0,    0, bpa_pkg::ST_OK,       0, 0,    0),
            row(bpa_pkg::ACT_FREE,  1024, 0,    1, bpa_pkg::ST_NO_BLOCK, 0, 0,    512)
        };
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (directed[n])
            issue(directed[n].req, directed[n].known, directed[n].res);
        drain_and_configure(5);
        issue('{bpa_pkg::ACT_ALLOC, 11'd8, 10'd0}, 1'b1,
              '{bpa_pkg::ST_BAD_REQ, 10'd0, 11'd0, 11'd5});
        issue('{bpa_pkg::ACT_FREE, 11'd1, 10'd5}, 1'b1,
              '{bpa_pkg::ST_BAD_REQ, 10'd0, 11'd0, 11'd5});
        issue('{bpa_pkg::ACT_ALLOC, 11'd4, 10'd0}, 1'b0, '0);
        issue('{bpa_pkg::ACT_ALLOC, 11'd2, 10'd0}, 1'b0, '0);
        foreach (settings[s])
        begin
            drain_and_configure(settings[s]);
            quiet = (s == 2);
            for (int n = 0; n < 135; n++)
                issue(rand_request(), 1'b0, '0);
        end
        quiet = 1'b0;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        $display("Sent %0d request words over %0d region settings, checked %0d results.",
                 words_sent, 8, results_seen);
        if (err_count == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
